### rtl/fla_pkg.sv
`timescale 1ns / 1ps
package fla_pkg;

	localparam int ADDR_W     = 64;
	localparam int OFF_W      = 32;
	localparam int LEN_W      = 33;
	localparam int SIZE_W     = 32;
	localparam int ALIGN_W    = 13;
	localparam int PAD_W      = 13;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [OFF_W-1:0]   RESET_POOL_SIZE = 32'd65536;
	localparam logic [ALIGN_W-1:0] MIN_ALIGN       = 13'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_REINIT = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_OOM     = 3'd1,
		ST_ALIGN   = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POOL_BASE = 2'd0,
		CFG_POOL_SIZE = 2'd1,
		CFG_PLACEMENT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pool_base;
		logic [OFF_W-1:0]  pool_size;
		logic              best_fit;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [SIZE_W-1:0]  request_size;
		logic [ALIGN_W-1:0] align_bytes;
		logic [ADDR_W-1:0]  release_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] granted_address;
		status_t           status;
		logic [SIZE_W-1:0] used_bytes;
		logic [SIZE_W-1:0] peak_bytes;
	} res_t;

	typedef struct packed {
		logic              fit;
		logic [PAD_W-1:0]  pad;
		logic [LEN_W-1:0]  need;
		logic [LEN_W-1:0]  diff;
	} fit_t;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [LEN_W-1:0] length;
	} seg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] data;
		logic [OFF_W-1:0]  block_start;
		logic [LEN_W-1:0]  block_length;
	} rec_t;

endpackage

### rtl/fla_if.sv
`timescale 1ns / 1ps
interface fla_cmd_if;
	import fla_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [SIZE_W-1:0]  request_size;
	logic [ALIGN_W-1:0] align_bytes;
	logic [ADDR_W-1:0]  release_addr;

	modport source (output valid, output command, output request_size,
		output align_bytes, output release_addr, input ready);
	modport sink (input valid, input command, input request_size,
		input align_bytes, input release_addr, output ready);
endinterface

interface fla_rsp_if;
	import fla_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] granted_address;
	logic [2:0]        status;
	logic [SIZE_W-1:0] used_bytes;
	logic [SIZE_W-1:0] peak_bytes;

	modport source (output valid, output granted_address, output status,
		output used_bytes, output peak_bytes, input ready);
	modport sink (input valid, input granted_address, input status,
		input used_bytes, input peak_bytes, output ready);
endinterface

### rtl/fla_fit.sv
`timescale 1ns / 1ps
module fla_fit #(
	parameter int HEADER_BYTES = 16
) (
	input  logic [fla_pkg::ALIGN_W-1:0] base_lo,
	input  fla_pkg::seg_t               seg,
	input  logic [fla_pkg::SIZE_W-1:0]  size,
	input  logic [fla_pkg::ALIGN_W-1:0] align,
	output fla_pkg::fit_t               fit
);
	import fla_pkg::*;

	logic [ALIGN_W-1:0] sum;
	logic [ALIGN_W-1:0] mask;
	logic [ALIGN_W-1:0] rem;
	logic [PAD_W-1:0]   pad;
	logic [LEN_W-1:0]   req;

	// low address bits after the header, reduced by the alignment
	assign sum  = base_lo + seg.start[ALIGN_W-1:0] + ALIGN_W'(HEADER_BYTES);
	assign mask = align - ALIGN_W'(1);
	assign rem  = sum & mask;
	assign pad  = PAD_W'(HEADER_BYTES) + ((rem != '0) ? PAD_W'(align - rem) : '0);
	assign req  = LEN_W'(size) + LEN_W'(pad);

	assign fit.fit  = (seg.length >= req);
	assign fit.pad  = pad;
	assign fit.need = req;
	assign fit.diff = seg.length - req;

endmodule

### rtl/fla_ctrl.sv
`timescale 1ns / 1ps
module fla_ctrl #(
	parameter int MAX_SEGMENTS = 64,
	parameter int MAX_RECORDS  = 256,
	parameter int HEADER_BYTES = 16,
	parameter int NODE_BYTES   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fla_pkg::cfg_t cfg,
	input  logic          start,
	input  fla_pkg::req_t req,
	output logic          idle,
	input  logic          out_free,
	output logic          done,
	output fla_pkg::res_t res
);
	import fla_pkg::*;

	localparam int SEG_IW = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int REC_IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int RC_W   = REC_IW + 1;
	localparam int SUM_W  = LEN_W + 1;

	typedef enum logic [11:0] {
		S_INIT     = 12'b000000000001,
		S_IDLE     = 12'b000000000010,
		S_A_SCAN   = 12'b000000000100,
		S_A_SLOT   = 12'b000000001000,
		S_A_COMMIT = 12'b000000010000,
		S_F_LOOK   = 12'b000000100000,
		S_F_SEG    = 12'b000001000000,
		S_F_MERGE  = 12'b000010000000,
		S_SHIFT_DN = 12'b000100000000,
		S_SHIFT_UP = 12'b001000000000,
		S_F_PLACE  = 12'b010000000000,
		S_DONE     = 12'b100000000000
	} state_t;

	seg_t seg_mem [MAX_SEGMENTS];
	rec_t rec_mem [MAX_RECORDS];

	state_t             state_q;
	logic [CNT_W-1:0]   seg_cnt_q;
	logic [MAX_RECORDS-1:0] rec_valid_q;
	req_t               req_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               rd_stop_q;
	logic               vld_s1;
	logic [CNT_W-1:0]   idx_s1;
	seg_t               seg_rd_s1;
	logic [RC_W-1:0]    rc_q;
	logic               rvld_s1;
	logic [REC_IW-1:0]  ridx_s1;
	rec_t               rec_rd_s1;
	logic               found_q;
	logic [SEG_IW-1:0]  best_idx_q;
	logic [PAD_W-1:0]   best_pad_q;
	logic [LEN_W-1:0]   best_diff_q;
	seg_t               best_seg_q;
	logic [REC_IW-1:0]  slot_q;
	logic [REC_IW-1:0]  rec_idx_q;
	rec_t               blk_q;
	seg_t               prev_q;
	seg_t               next_q;
	logic               have_prev_q;
	logic               have_next_q;
	logic [CNT_W-1:0]   p_q;
	logic [LEN_W-1:0]   used_q;
	logic [LEN_W-1:0]   peak_q;
	status_t            status_q;
	logic [ADDR_W-1:0]  granted_q;

	fit_t               fit;
	logic               seg_we;
	logic [SEG_IW-1:0]  seg_waddr;
	seg_t               seg_wdata;
	logic [SEG_IW-1:0]  seg_raddr;
	logic               rec_we;
	rec_t               rec_wdata;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   idx_dn;
	logic [CNT_W-1:0]   idx_up;
	logic [CNT_W-1:0]   p_m1;
	logic               align_ok;
	logic               better;
	logic               scan_stop;
	logic               found_any;
	logic [LEN_W-1:0]   need;
	logic               absorb;
	logic [LEN_W-1:0]   blen;
	logic [ADDR_W-1:0]  granted_c;
	logic [LEN_W-1:0]   used_add;
	logic               rec_hit;
	logic               jn;
	logic               jp;
	logic               seg_full;

	fla_fit #(.HEADER_BYTES(HEADER_BYTES)) u_fit (
		.base_lo (cfg.pool_base[ALIGN_W-1:0]),
		.seg     (seg_rd_s1),
		.size    (req_q.request_size),
		.align   (req_q.align_bytes),
		.fit     (fit)
	);

	assign cnt_m1    = seg_cnt_q - CNT_W'(1);
	assign idx_dn    = idx_s1 - CNT_W'(1);
	assign idx_up    = idx_s1 + CNT_W'(1);
	assign p_m1      = p_q - CNT_W'(1);
	assign align_ok  = (req.align_bytes >= MIN_ALIGN) &&
		((req.align_bytes & (req.align_bytes - ALIGN_W'(1))) == '0);
	assign better    = fit.fit && (!found_q || (fit.diff < best_diff_q));
	assign scan_stop = vld_s1 && ((fit.fit && !cfg.best_fit) || (idx_s1 == cnt_m1));
	assign found_any = found_q || (vld_s1 && fit.fit);
	assign need      = LEN_W'(req_q.request_size) + LEN_W'(best_pad_q);
	assign absorb    = best_diff_q < LEN_W'(NODE_BYTES);
	assign blen      = absorb ? best_seg_q.length : need;
	assign granted_c = cfg.pool_base + ADDR_W'(best_seg_q.start) + ADDR_W'(best_pad_q);
	assign used_add  = used_q + blen;
	assign rec_hit   = rvld_s1 && rec_valid_q[ridx_s1] &&
		(rec_rd_s1.data == req_q.release_addr);
	assign jn = have_next_q &&
		((SUM_W'(blk_q.block_start) + SUM_W'(blk_q.block_length)) == SUM_W'(next_q.start));
	assign jp = have_prev_q &&
		((SUM_W'(prev_q.start) + SUM_W'(prev_q.length)) == SUM_W'(blk_q.block_start));
	assign seg_full  = !jp && !jn && (seg_cnt_q >= CNT_W'(MAX_SEGMENTS));
	assign seg_raddr = rd_idx_q[SEG_IW-1:0];

	// segment and record table write ports
	always_comb begin
		seg_we    = 1'b0;
		seg_waddr = p_q[SEG_IW-1:0];
		seg_wdata = '{start: blk_q.block_start, length: blk_q.block_length};
		rec_we    = 1'b0;
		rec_wdata = '{data: granted_c, block_start: best_seg_q.start, block_length: blen};
		unique case (state_q)
			S_INIT: begin
				seg_we    = 1'b1;
				seg_waddr = '0;
				seg_wdata = '{start: '0, length: LEN_W'(RESET_POOL_SIZE)};
			end
			S_IDLE: begin
				if (start && (req.command == CMD_REINIT)) begin
					seg_we    = 1'b1;
					seg_waddr = '0;
					seg_wdata = '{start: '0, length: LEN_W'(cfg.pool_size)};
				end
			end
			S_A_COMMIT: begin
				rec_we = 1'b1;
				if (!absorb) begin
					seg_we    = 1'b1;
					seg_waddr = best_idx_q;
					seg_wdata = '{start: best_seg_q.start + need[OFF_W-1:0],
						length: best_diff_q};
				end
			end
			S_F_MERGE: begin
				if (jp) begin
					seg_we    = 1'b1;
					seg_waddr = p_m1[SEG_IW-1:0];
					seg_wdata = '{start: prev_q.start,
						length: prev_q.length + blk_q.block_length +
							(jn ? next_q.length : '0)};
				end else if (jn) begin
					seg_we    = 1'b1;
					seg_wdata = '{start: blk_q.block_start,
						length: next_q.length + blk_q.block_length};
				end else if (!seg_full && (p_q == seg_cnt_q)) begin
					seg_we = 1'b1;
				end
			end
			S_SHIFT_DN: begin
				if (vld_s1) begin
					seg_we    = 1'b1;
					seg_waddr = idx_dn[SEG_IW-1:0];
					seg_wdata = seg_rd_s1;
				end
			end
			S_SHIFT_UP: begin
				if (vld_s1) begin
					seg_we    = 1'b1;
					seg_waddr = idx_up[SEG_IW-1:0];
					seg_wdata = seg_rd_s1;
				end
			end
			S_F_PLACE: seg_we = 1'b1;
			default: seg_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		seg_rd_s1 <= seg_mem[seg_raddr];
		if (seg_we)
			seg_mem[seg_waddr] <= seg_wdata;
	end

	always_ff @(posedge clk) begin
		rec_rd_s1 <= rec_mem[rc_q[REC_IW-1:0]];
		if (rec_we)
			rec_mem[slot_q] <= rec_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			seg_cnt_q   <= CNT_W'(1);
			rec_valid_q <= '0;
			req_q       <= '0;
			rd_idx_q    <= '0;
			rd_stop_q   <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			rc_q        <= '0;
			rvld_s1     <= 1'b0;
			ridx_s1     <= '0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_pad_q  <= '0;
			best_diff_q <= '0;
			best_seg_q  <= '0;
			slot_q      <= '0;
			rec_idx_q   <= '0;
			blk_q       <= '0;
			prev_q      <= '0;
			next_q      <= '0;
			have_prev_q <= 1'b0;
			have_next_q <= 1'b0;
			p_q         <= '0;
			used_q      <= '0;
			peak_q      <= '0;
			status_q    <= ST_OK;
			granted_q   <= '0;
		end else begin
			vld_s1  <= 1'b0;
			rvld_s1 <= 1'b0;
			unique case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (start) begin
						req_q       <= req;
						granted_q   <= '0;
						status_q    <= ST_OK;
						rd_idx_q    <= '0;
						rd_stop_q   <= 1'b0;
						rc_q        <= '0;
						found_q     <= 1'b0;
						slot_q      <= '0;
						have_prev_q <= 1'b0;
						have_next_q <= 1'b0;
						case (req.command)
							CMD_ALLOC: begin
								if (!align_ok) begin
									status_q <= ST_ALIGN;
									state_q  <= S_DONE;
								end else if (seg_cnt_q == '0) begin
									status_q <= ST_OOM;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_A_SCAN;
								end
							end
							CMD_FREE: state_q <= S_F_LOOK;
							CMD_REINIT: begin
								seg_cnt_q   <= CNT_W'(1);
								rec_valid_q <= '0;
								used_q      <= '0;
								peak_q      <= '0;
								state_q     <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_A_SCAN: begin
					if (rd_idx_q < seg_cnt_q) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
						vld_s1   <= 1'b1;
						idx_s1   <= rd_idx_q;
					end
					if (vld_s1 && better) begin
						found_q     <= 1'b1;
						best_idx_q  <= idx_s1[SEG_IW-1:0];
						best_pad_q  <= fit.pad;
						best_diff_q <= fit.diff;
						best_seg_q  <= seg_rd_s1;
					end
					if (scan_stop) begin
						vld_s1 <= 1'b0;
						if (found_any) begin
							state_q <= S_A_SLOT;
						end else begin
							status_q <= ST_OOM;
							state_q  <= S_DONE;
						end
					end
				end
				S_A_SLOT: begin
					if (!rec_valid_q[slot_q]) begin
						state_q <= S_A_COMMIT;
					end else if (slot_q == REC_IW'(MAX_RECORDS - 1)) begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						slot_q <= slot_q + REC_IW'(1);
					end
				end
				S_A_COMMIT: begin
					rec_valid_q[slot_q] <= 1'b1;
					used_q    <= used_add;
					granted_q <= granted_c;
					if (used_add > peak_q)
						peak_q <= used_add;
					if (absorb && (CNT_W'(best_idx_q) != cnt_m1)) begin
						rd_idx_q <= CNT_W'(best_idx_q) + CNT_W'(1);
						state_q  <= S_SHIFT_DN;
					end else begin
						if (absorb)
							seg_cnt_q <= cnt_m1;
						state_q <= S_DONE;
					end
				end
				S_SHIFT_DN: begin
					if (rd_idx_q < seg_cnt_q) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
						vld_s1   <= 1'b1;
						idx_s1   <= rd_idx_q;
					end
					if (vld_s1 && (idx_s1 == cnt_m1)) begin
						vld_s1    <= 1'b0;
						seg_cnt_q <= cnt_m1;
						state_q   <= S_DONE;
					end
				end
				S_F_LOOK: begin
					if (rc_q < RC_W'(MAX_RECORDS)) begin
						rc_q    <= rc_q + RC_W'(1);
						rvld_s1 <= 1'b1;
						ridx_s1 <= rc_q[REC_IW-1:0];
					end
					if (rec_hit) begin
						rvld_s1   <= 1'b0;
						rec_idx_q <= ridx_s1;
						blk_q     <= rec_rd_s1;
						if (seg_cnt_q == '0) begin
							p_q     <= '0;
							state_q <= S_F_MERGE;
						end else begin
							state_q <= S_F_SEG;
						end
					end else if (rvld_s1 && (ridx_s1 == REC_IW'(MAX_RECORDS - 1))) begin
						status_q <= ST_UNKNOWN;
						state_q  <= S_DONE;
					end
				end
				S_F_SEG: begin
					if (rd_idx_q < seg_cnt_q) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
						vld_s1   <= 1'b1;
						idx_s1   <= rd_idx_q;
					end
					if (vld_s1) begin
						if (seg_rd_s1.start > blk_q.block_start) begin
							p_q         <= idx_s1;
							have_next_q <= 1'b1;
							next_q      <= seg_rd_s1;
							vld_s1      <= 1'b0;
							state_q     <= S_F_MERGE;
						end else begin
							have_prev_q <= 1'b1;
							prev_q      <= seg_rd_s1;
							if (idx_s1 == cnt_m1) begin
								p_q     <= seg_cnt_q;
								vld_s1  <= 1'b0;
								state_q <= S_F_MERGE;
							end
						end
					end
				end
				S_F_MERGE: begin
					if (seg_full) begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						rec_valid_q[rec_idx_q] <= 1'b0;
						used_q <= used_q - blk_q.block_length;
						if (jp && jn) begin
							if (p_q == cnt_m1) begin
								seg_cnt_q <= cnt_m1;
								state_q   <= S_DONE;
							end else begin
								rd_idx_q <= p_q + CNT_W'(1);
								state_q  <= S_SHIFT_DN;
							end
						end else if (jp || jn) begin
							state_q <= S_DONE;
						end else if (p_q == seg_cnt_q) begin
							seg_cnt_q <= seg_cnt_q + CNT_W'(1);
							state_q   <= S_DONE;
						end else begin
							rd_idx_q  <= cnt_m1;
							rd_stop_q <= 1'b0;
							state_q   <= S_SHIFT_UP;
						end
					end
				end
				S_SHIFT_UP: begin
					if (!rd_stop_q) begin
						vld_s1   <= 1'b1;
						idx_s1   <= rd_idx_q;
						rd_idx_q <= rd_idx_q - CNT_W'(1);
						if (rd_idx_q == p_q)
							rd_stop_q <= 1'b1;
					end
					if (vld_s1 && (idx_s1 == p_q)) begin
						vld_s1  <= 1'b0;
						state_q <= S_F_PLACE;
					end
				end
				S_F_PLACE: begin
					seg_cnt_q <= seg_cnt_q + CNT_W'(1);
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE) && out_free;
	assign res  = '{granted_address: granted_q, status: status_q,
		used_bytes: used_q[SIZE_W-1:0], peak_bytes: peak_q[SIZE_W-1:0]};

endmodule

### rtl/free_list_allocator_core.sv
`timescale 1ns / 1ps
// Free-list allocator for one memory pool.
// Command words enter on cmd (allocate, free, reinitialize); every command
// gives exactly one response word on rsp with the granted address, a status
// and the used and peak byte counts. Both channels are valid/ready.
// The pool base, pool size and placement mode are written on the cfg port;
// the user must write them only while the block is idle, which the block
// itself does not enforce. The size applies at the next reinitialize; the
// base and placement mode are read directly by each command.
// An allocate scans the free segments, searches for a record slot, commits
// and, if it used a segment up, closes that segment's table slot. A free
// looks up the record, searches the segments, merges, and opens or closes a
// table slot where needed. Reinitialize and bad-alignment rejects go
// straight to the response.
// The segment and record memories are each read one entry per cycle
// through a single read port. One command is in flight at a time.
// After reset the block builds the whole-pool segment in its init state
// and then takes commands. When rsp stalls, the finished word waits in the
// output register, the next command is still taken and runs until its own
// result is due, then holds until the register frees.
module free_list_allocator_core #(
	parameter int MAX_SEGMENTS = 64,
	parameter int MAX_RECORDS  = 256,
	parameter int HEADER_BYTES = 16,
	parameter int NODE_BYTES   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fla_cmd_if.sink                        cmd,
	fla_rsp_if.source                      rsp,
	input  logic                           cfg_write,
	input  logic [fla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fla_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fla_pkg::*;

	cfg_t cfg_q;
	req_t req;
	res_t res;
	res_t rsp_q;
	logic rsp_valid_q;
	logic idle;
	logic done;
	logic out_free;
	logic start;

	// configuration registers; writes to unused indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pool_base: '0, pool_size: RESET_POOL_SIZE, best_fit: 1'b0};
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_POOL_BASE: cfg_q.pool_base <= cfg_data;
				CFG_POOL_SIZE: cfg_q.pool_size <= cfg_data[OFF_W-1:0];
				CFG_PLACEMENT: cfg_q.best_fit  <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// take a command only when the controller sits idle
	assign cmd.ready = idle;
	assign start     = cmd.valid && idle;
	assign req       = '{command: cmd.command, request_size: cmd.request_size,
		align_bytes: cmd.align_bytes, release_addr: cmd.release_addr};

	// output register frees when empty or drained this cycle
	assign out_free = !rsp_valid_q || rsp.ready;

	fla_ctrl #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.MAX_RECORDS  (MAX_RECORDS),
		.HEADER_BYTES (HEADER_BYTES),
		.NODE_BYTES   (NODE_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (start),
		.req      (req),
		.idle     (idle),
		.out_free (out_free),
		.done     (done),
		.res      (res)
	);

	// hold the response word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.granted_address = rsp_q.granted_address;
	assign rsp.status          = rsp_q.status;
	assign rsp.used_bytes      = rsp_q.used_bytes;
	assign rsp.peak_bytes      = rsp_q.peak_bytes;

endmodule
